// File: rtl/plstat_pkg.sv
package plstat_pkg;

	localparam int TIME_W     = 37;
	localparam int DELAY_W    = 30;
	localparam int MINUTE_W   = 12;
	localparam int OUT_MIN_W  = 11;
	localparam int COUNT_W    = 32;
	localparam int SUM_W      = 64;
	localparam int KIND_W     = 2;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int QUOT_W     = 30;
	localparam int STEP_W     = 5;

	// minute = ((recv >> 8) * ceil(2^47 / 234375)) >> 47, exact for a 29-bit operand
	localparam int MINUTE_PRE_SHIFT   = 8;
	localparam int RECIP_W            = 30;
	localparam int MIN_PROD_W         = TIME_W - MINUTE_PRE_SHIFT + RECIP_W;
	localparam int MINUTE_RECIP_SHIFT = 47;

	localparam logic [COUNT_W-1:0]  US_PER_MINUTE      = 32'd60000000;
	localparam logic [RECIP_W-1:0]  MINUTE_RECIP       = 30'd600479951;
	localparam logic [MINUTE_W-1:0] MINUTE_EMPTY       = '1;
	localparam logic [COUNT_W-1:0]  COUNT_MAX          = '1;
	localparam logic [DELAY_W-1:0]  PUSH_LIMIT_RST     = 30'd600000000;
	localparam logic [DELAY_W-1:0]  INTERNAL_LIMIT_RST = 30'd60000000;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;

	localparam logic REG_PUSH_LIMIT     = 1'b0;
	localparam logic REG_INTERNAL_LIMIT = 1'b1;

	localparam logic [STEP_W-1:0] MEAN_STEPS   = 5'd30;

	typedef struct packed {
		logic              req_type;
		logic              source;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] recv_time_us;
		logic [TIME_W-1:0] other_time_us;
		logic              force_req;
	} plstat_req_t;

	typedef struct packed {
		logic                 out_source;
		logic [KIND_W-1:0]    out_kind;
		logic [OUT_MIN_W-1:0] minute_of_day;
		logic [COUNT_W-1:0]   sample_count;
		logic [DELAY_W-1:0]   min_delay_us;
		logic [DELAY_W-1:0]   max_delay_us;
		logic [DELAY_W-1:0]   mean_delay_us;
		logic                 last;
	} plstat_stat_t;

	typedef struct packed {
		logic take;
		logic div_minute;
		logic div_mean;
		logic minute_store;
		logic setup_sample;
		logic setup_flush;
		logic idx_inc;
		logic out_load;
		logic clear;
		logic update;
	} plstat_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic is_flush;
		logic sample_ok;
		logic differ;
		logic occupied;
		logic hit;
		logic idx_last;
		logic div_busy;
		logic out_free;
	} plstat_sts_t;

endpackage

// File: rtl/plstat_ifs.sv
interface plstat_req_if;
	logic                      valid;
	logic                      ready;
	plstat_pkg::plstat_req_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface plstat_stat_if;
	logic                      valid;
	logic                      ready;
	plstat_pkg::plstat_stat_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/plstat_div.sv
module plstat_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [plstat_pkg::STEP_W-1:0]       steps,
	input  logic [plstat_pkg::COUNT_W-1:0]      rem_init,
	input  logic [plstat_pkg::QUOT_W-1:0]       dividend_lo,
	input  logic [plstat_pkg::COUNT_W-1:0]      divisor,
	output logic                                busy,
	output logic [plstat_pkg::QUOT_W-1:0]       quotient
);

	logic [plstat_pkg::COUNT_W-1:0] rem_q;
	logic [plstat_pkg::QUOT_W-1:0]  lo_q;
	logic [plstat_pkg::QUOT_W-1:0]  quo_q;
	logic [plstat_pkg::COUNT_W-1:0] div_q;
	logic [plstat_pkg::STEP_W-1:0]  cnt_q;
	logic                           busy_q;

	logic [plstat_pkg::COUNT_W:0]   trial;
	logic [plstat_pkg::COUNT_W+1:0] diff;
	logic                           ge;

	assign trial = {rem_q, lo_q[plstat_pkg::QUOT_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign ge    = ~diff[plstat_pkg::COUNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == plstat_pkg::STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			lo_q  <= dividend_lo;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[plstat_pkg::COUNT_W-1:0] : trial[plstat_pkg::COUNT_W-1:0];
			lo_q  <= {lo_q[plstat_pkg::QUOT_W-2:0], 1'b0};
			quo_q <= {quo_q[plstat_pkg::QUOT_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: rtl/plstat_dp.sv
module plstat_dp #(
	parameter int NUM_KINDS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	plstat_req_if.sink                          req,
	plstat_stat_if.source                       stats,
	input  logic [plstat_pkg::DELAY_W-1:0]      push_limit_us,
	input  logic [plstat_pkg::DELAY_W-1:0]      internal_limit_us,
	input  plstat_pkg::plstat_cmd_t             cmd,
	output plstat_pkg::plstat_sts_t             sts
);

	localparam int NB    = 2 * NUM_KINDS;
	localparam int IDX_W = $clog2(NB);

	plstat_pkg::plstat_req_t               req_q;
	logic [plstat_pkg::MINUTE_W-1:0]       minute_q;
	logic [plstat_pkg::MIN_PROD_W-1:0]     minute_prod_q;
	logic [plstat_pkg::DELAY_W-1:0]        d_q;
	logic [IDX_W-1:0]                      idx_q;
	logic [NB-1:0]                         mask_q;
	plstat_pkg::plstat_stat_t              stat_q;
	logic                                  out_valid_q;

	logic [plstat_pkg::MINUTE_W-1:0] bkt_minute_q [NB];
	logic [plstat_pkg::COUNT_W-1:0]  bkt_count_q  [NB];
	logic [plstat_pkg::DELAY_W-1:0]  bkt_min_q    [NB];
	logic [plstat_pkg::DELAY_W-1:0]  bkt_max_q    [NB];
	logic [plstat_pkg::SUM_W-1:0]    bkt_sum_q    [NB];

	logic [plstat_pkg::TIME_W-1:0]   a_time;
	logic [plstat_pkg::TIME_W-1:0]   b_time;
	logic [plstat_pkg::TIME_W:0]     delay;
	logic [plstat_pkg::DELAY_W-1:0]  lim;
	logic                            kind_ok;
	logic [IDX_W-1:0]                sample_idx;
	logic [plstat_pkg::MIN_PROD_W-1:0] minute_prod;

	logic [plstat_pkg::MINUTE_W-1:0] sel_minute;
	logic [plstat_pkg::COUNT_W-1:0]  sel_count;
	logic [plstat_pkg::DELAY_W-1:0]  sel_min;
	logic [plstat_pkg::DELAY_W-1:0]  sel_max;
	logic [plstat_pkg::SUM_W-1:0]    sel_sum;

	logic [NB-1:0]                   qual;
	logic                            any_later;
	logic                            hi_src;
	logic [IDX_W-1:0]                kind_idx;
	logic                            out_free;

	logic                            div_start;
	logic                            div_busy;
	logic [plstat_pkg::COUNT_W-1:0]  div_rem;
	logic [plstat_pkg::QUOT_W-1:0]   div_lo;
	logic [plstat_pkg::COUNT_W-1:0]  div_divisor;
	logic [plstat_pkg::STEP_W-1:0]   div_steps;
	logic [plstat_pkg::QUOT_W-1:0]   quotient;

	assign req.ready = cmd.take;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			req_q <= req.data;
	end

	// delay and limit check
	assign a_time  = req_q.source ? req_q.other_time_us : req_q.recv_time_us;
	assign b_time  = req_q.source ? req_q.recv_time_us : req_q.other_time_us;
	assign delay   = {1'b0, a_time} - {1'b0, b_time};
	assign lim     = req_q.source ? internal_limit_us : push_limit_us;
	assign kind_ok = {2'b00, req_q.kind} < 4'(NUM_KINDS);
	assign sample_idx = (req_q.source ? IDX_W'(NUM_KINDS) : '0) + IDX_W'(req_q.kind);

	// minute of day by reciprocal multiplication
	assign minute_prod = plstat_pkg::MIN_PROD_W'(
			req_q.recv_time_us[plstat_pkg::TIME_W-1:plstat_pkg::MINUTE_PRE_SHIFT])
		* plstat_pkg::MIN_PROD_W'(plstat_pkg::MINUTE_RECIP);

	assign sel_minute = bkt_minute_q[idx_q];
	assign sel_count  = bkt_count_q[idx_q];
	assign sel_min    = bkt_min_q[idx_q];
	assign sel_max    = bkt_max_q[idx_q];
	assign sel_sum    = bkt_sum_q[idx_q];

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			qual[j] = (bkt_count_q[j] != '0) && (bkt_minute_q[j] != plstat_pkg::MINUTE_EMPTY)
				&& (req_q.force_req || (bkt_minute_q[j] < minute_q));
		end
	end

	always_comb begin
		any_later = 1'b0;
		for (int j = 0; j < NB; j++) begin
			if ((IDX_W'(j) > idx_q) && mask_q[j])
				any_later = 1'b1;
		end
	end

	assign hi_src   = idx_q >= IDX_W'(NUM_KINDS);
	assign kind_idx = hi_src ? idx_q - IDX_W'(NUM_KINDS) : idx_q;

	// serial divider for the bucket mean
	assign div_start   = cmd.div_mean;
	assign div_rem     = sel_sum[61:30];
	assign div_lo      = sel_sum[29:0];
	assign div_divisor = sel_count;
	assign div_steps   = plstat_pkg::MEAN_STEPS;

	plstat_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.steps       (div_steps),
		.rem_init    (div_rem),
		.dividend_lo (div_lo),
		.divisor     (div_divisor),
		.busy        (div_busy),
		.quotient    (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_minute)
			minute_prod_q <= minute_prod;
		if (cmd.minute_store)
			minute_q <= minute_prod_q[plstat_pkg::MIN_PROD_W-1:plstat_pkg::MINUTE_RECIP_SHIFT];
		if (cmd.setup_sample)
			d_q <= delay[plstat_pkg::DELAY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			mask_q <= '0;
		end else if (cmd.setup_sample) begin
			idx_q <= sample_idx;
		end else if (cmd.setup_flush) begin
			idx_q  <= '0;
			mask_q <= qual;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NB; j++) begin
				bkt_minute_q[j] <= plstat_pkg::MINUTE_EMPTY;
				bkt_count_q[j]  <= '0;
				bkt_min_q[j]    <= '0;
				bkt_max_q[j]    <= '0;
				bkt_sum_q[j]    <= '0;
			end
		end else if (cmd.clear) begin
			bkt_minute_q[idx_q] <= req_q.req_type ? plstat_pkg::MINUTE_EMPTY : minute_q;
			bkt_count_q[idx_q]  <= '0;
			bkt_min_q[idx_q]    <= '0;
			bkt_max_q[idx_q]    <= '0;
			bkt_sum_q[idx_q]    <= '0;
		end else if (cmd.update) begin
			if (sel_count == '0) begin
				bkt_min_q[idx_q] <= d_q;
				bkt_max_q[idx_q] <= d_q;
			end else begin
				if (d_q < sel_min)
					bkt_min_q[idx_q] <= d_q;
				if (d_q > sel_max)
					bkt_max_q[idx_q] <= d_q;
			end
			if (sel_count != plstat_pkg::COUNT_MAX) begin
				bkt_count_q[idx_q] <= sel_count + 1'b1;
				bkt_sum_q[idx_q]   <= sel_sum + {34'd0, d_q};
			end
		end
	end

	// result register
	assign out_free = ~out_valid_q | stats.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (stats.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			stat_q.out_source    <= hi_src;
			stat_q.out_kind      <= kind_idx[plstat_pkg::KIND_W-1:0] & {plstat_pkg::KIND_W{1'b1}};
			stat_q.minute_of_day <= sel_minute[plstat_pkg::OUT_MIN_W-1:0];
			stat_q.sample_count  <= sel_count;
			stat_q.min_delay_us  <= sel_min;
			stat_q.max_delay_us  <= sel_max;
			stat_q.mean_delay_us <= quotient;
			stat_q.last          <= (req_q.req_type == plstat_pkg::REQ_FLUSH) ? ~any_later : 1'b1;
		end
	end

	assign stats.valid = out_valid_q;
	assign stats.data  = stat_q;

	assign sts.req_valid = req.valid;
	assign sts.is_flush  = req_q.req_type == plstat_pkg::REQ_FLUSH;
	assign sts.sample_ok = ~delay[plstat_pkg::TIME_W]
		&& (delay[plstat_pkg::TIME_W-1:0] <= {7'd0, lim}) && kind_ok;
	assign sts.differ    = sel_minute != minute_q;
	assign sts.occupied  = (sel_count != '0) && (sel_minute != plstat_pkg::MINUTE_EMPTY);
	assign sts.hit       = mask_q[idx_q];
	assign sts.idx_last  = idx_q == IDX_W'(NB - 1);
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = out_free;

endmodule

// File: rtl/plstat_ctrl.sv
module plstat_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plstat_pkg::plstat_sts_t    sts,
	output plstat_pkg::plstat_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MDIV,
		S_MWAIT,
		S_SETUP,
		S_SCHK,
		S_FSCAN,
		S_EDIV,
		S_EWAIT,
		S_EOUT,
		S_CLEAR,
		S_UPDATE
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (sts.req_valid)
					state_nx = S_MDIV;
			end
			S_MDIV: begin
				cmd.div_minute = 1'b1;
				state_nx       = S_MWAIT;
			end
			S_MWAIT: begin
				cmd.minute_store = 1'b1;
				state_nx         = S_SETUP;
			end
			S_SETUP: begin
				if (sts.is_flush) begin
					cmd.setup_flush = 1'b1;
					state_nx        = S_FSCAN;
				end else if (sts.sample_ok) begin
					cmd.setup_sample = 1'b1;
					state_nx         = S_SCHK;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_SCHK: begin
				if (sts.differ && sts.occupied)
					state_nx = S_EDIV;
				else if (sts.differ)
					state_nx = S_CLEAR;
				else
					state_nx = S_UPDATE;
			end
			S_FSCAN: begin
				if (sts.hit) begin
					state_nx = S_EDIV;
				end else if (sts.idx_last) begin
					state_nx = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_EDIV: begin
				cmd.div_mean = 1'b1;
				state_nx     = S_EWAIT;
			end
			S_EWAIT: begin
				if (!sts.div_busy)
					state_nx = S_EOUT;
			end
			S_EOUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_CLEAR;
				end
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (!sts.is_flush) begin
					state_nx = S_UPDATE;
				end else if (sts.idx_last) begin
					state_nx = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = S_FSCAN;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/per_minute_latency_statistics_core.sv
// Per-minute latency statistics over 2*NUM_KINDS buckets (push and internal source, one
// per kind). Each request is a latency sample or a flush; results are one record per
// emitted bucket with count, min, max and truncated mean, the final record of a request
// marked by last. One request is worked at a time: the minute of day comes from a
// registered reciprocal multiplication (product register, then minute register), and a
// sample that closes the old minute of its bucket also runs a 30-step mean division and
// a result load. A flush walks every bucket and emits each occupied one of an older
// minute, or each occupied one when forced. The result register lets the next request
// start while a record waits to be taken. Limits are written over the APB port at 0x0
// (push) and 0x4 (internal), only while idle; the block itself does not enforce this.
module per_minute_latency_statistics_core #(
	parameter int NUM_KINDS = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	plstat_req_if.sink                         req,
	plstat_stat_if.source                      stats,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [plstat_pkg::ADDR_W-1:0]      paddr,
	input  logic [plstat_pkg::DATA_W-1:0]      pwdata,
	output logic [plstat_pkg::DATA_W-1:0]      prdata,
	output logic                               pready
);

	logic [plstat_pkg::DELAY_W-1:0] push_limit_q;
	logic [plstat_pkg::DELAY_W-1:0] internal_limit_q;
	logic                           cfg_we;

	plstat_pkg::plstat_cmd_t cmd;
	plstat_pkg::plstat_sts_t sts;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_limit_q     <= plstat_pkg::PUSH_LIMIT_RST;
			internal_limit_q <= plstat_pkg::INTERNAL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				plstat_pkg::REG_PUSH_LIMIT:
					push_limit_q <= pwdata[plstat_pkg::DELAY_W-1:0];
				plstat_pkg::REG_INTERNAL_LIMIT:
					internal_limit_q <= pwdata[plstat_pkg::DELAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			plstat_pkg::REG_PUSH_LIMIT:     prdata = {2'b00, push_limit_q};
			plstat_pkg::REG_INTERNAL_LIMIT: prdata = {2'b00, internal_limit_q};
			default:                        prdata = '0;
		endcase
	end

	plstat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	plstat_dp #(
		.NUM_KINDS (NUM_KINDS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req),
		.stats             (stats),
		.push_limit_us     (push_limit_q),
		.internal_limit_us (internal_limit_q),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule

// File: bench/tb_top.sv
module tb_top;
	import plstat_pkg::*;

	localparam int KINDS = 3;
	localparam int BUCKETS = 2 * KINDS;
	localparam logic SRC_PUSH = 1'b0;
	localparam logic SRC_INTERNAL = 1'b1;
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ORDER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEAL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
	localparam longint TIME_MAX = (64'd1 << TIME_W) - 1;
	localparam longint MINUTE_US = 60000000;
	localparam int LAST_MINUTE = 2290;
	localparam int LIMIT_TOP = 1000000000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	class minute_bucket_tracker;
		logic [DELAY_W-1:0] push_limit;
		logic [DELAY_W-1:0] internal_limit;
		logic [MINUTE_W-1:0] minute_tag[BUCKETS];
		logic [COUNT_W-1:0] tally[BUCKETS];
		logic [DELAY_W-1:0] low_mark[BUCKETS];
		logic [DELAY_W-1:0] high_mark[BUCKETS];
		logic [SUM_W-1:0] total[BUCKETS];
		plstat_stat_t pending_records[$];
		int mismatch_count;
		int records_seen;

		function new();
			push_limit = PUSH_LIMIT_RST;
			internal_limit = INTERNAL_LIMIT_RST;
			for (int i = 0; i < BUCKETS; i++) wipe(i, MINUTE_EMPTY);
			mismatch_count = 0;
			records_seen = 0;
		endfunction

		function void set_limit(logic idx, logic [DATA_W-1:0] val);
			if (idx == REG_PUSH_LIMIT) push_limit = val[DELAY_W-1:0];
			else internal_limit = val[DELAY_W-1:0];
		endfunction

		function void wipe(int b, logic [MINUTE_W-1:0] mn);
			minute_tag[b] = mn;
			tally[b] = '0;
			low_mark[b] = '0;
			high_mark[b] = '0;
			total[b] = '0;
		endfunction

		function plstat_stat_t bucket_record(int b, logic fin);
			plstat_stat_t rec;
			rec.out_source = (b >= KINDS);
			rec.out_kind = KIND_W'(b % KINDS);
			rec.minute_of_day = minute_tag[b][OUT_MIN_W-1:0];
			rec.sample_count = tally[b];
			rec.min_delay_us = low_mark[b];
			rec.max_delay_us = high_mark[b];
			rec.mean_delay_us = DELAY_W'(total[b] / SUM_W'(tally[b]));
			rec.last = fin;
			return rec;
		endfunction

		function void absorb_request(plstat_req_t r);
			logic [MINUTE_W-1:0] mn;
			logic [TIME_W-1:0] late;
			logic [TIME_W-1:0] early;
			logic [DELAY_W-1:0] lim;
			logic [DELAY_W-1:0] dly;
			int b;
			int due[$];
			mn = MINUTE_W'(r.recv_time_us / TIME_W'(US_PER_MINUTE));
			if (r.req_type == REQ_FLUSH) begin
				for (int i = 0; i < BUCKETS; i++)
					if (tally[i] != 0 && minute_tag[i] != MINUTE_EMPTY &&
							(r.force_req || minute_tag[i] < mn))
						due.push_back(i);
				foreach (due[k]) begin
					pending_records.push_back(bucket_record(due[k], k == due.size() - 1));
					wipe(due[k], MINUTE_EMPTY);
				end
				return;
			end
			late = (r.source == SRC_INTERNAL) ? r.other_time_us : r.recv_time_us;
			early = (r.source == SRC_INTERNAL) ? r.recv_time_us : r.other_time_us;
			lim = (r.source == SRC_INTERNAL) ? internal_limit : push_limit;
			if (late < early || (late - early) > TIME_W'(lim)) return;
			if (r.kind >= KINDS) return;
			dly = DELAY_W'(late - early);
			b = r.source * KINDS + r.kind;
			if (minute_tag[b] != mn) begin
				if (tally[b] != 0 && minute_tag[b] != MINUTE_EMPTY)
					pending_records.push_back(bucket_record(b, 1'b1));
				wipe(b, mn);
			end
			if (tally[b] == 0) begin
				low_mark[b] = dly;
				high_mark[b] = dly;
			end else begin
				if (dly < low_mark[b]) low_mark[b] = dly;
				if (dly > high_mark[b]) high_mark[b] = dly;
			end
			if (tally[b] != COUNT_MAX) begin
				tally[b] = tally[b] + 1'b1;
				total[b] = total[b] + dly;
			end
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		endfunction

		function void match_record(plstat_stat_t got);
			plstat_stat_t want;
			records_seen++;
			if (pending_records.size() == 0) begin
				$display("%0t: unexpected record expected none actual %p", $time, got);
				mismatch_count++;
				return;
			end
			want = pending_records.pop_front();
			if (got === want) return;
			mismatch_count++;
			if (got.out_source !== want.out_source)
				report("out_source", want.out_source, got.out_source);
			if (got.out_kind !== want.out_kind)
				report("out_kind", want.out_kind, got.out_kind);
			if (got.minute_of_day !== want.minute_of_day)
				report("minute_of_day", want.minute_of_day, got.minute_of_day);
			if (got.sample_count !== want.sample_count)
				report("sample_count", want.sample_count, got.sample_count);
			if (got.min_delay_us !== want.min_delay_us)
				report("min_delay_us", want.min_delay_us, got.min_delay_us);
			if (got.max_delay_us !== want.max_delay_us)
				report("max_delay_us", want.max_delay_us, got.max_delay_us);
			if (got.mean_delay_us !== want.mean_delay_us)
				report("mean_delay_us", want.mean_delay_us, got.mean_delay_us);
			if (got.last !== want.last)
				report("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	plstat_req_if req_if();
	plstat_stat_if stats_if();

	minute_bucket_tracker board;
	bit src_gaps;
	bit sink_gaps;
	bit hold_output;
	int cur_minute;
	int requests_sent;
	int limit_settings;
	int idle_cycles = 0;

	per_minute_latency_statistics_core #(.NUM_KINDS(KINDS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.stats(stats_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always begin
		@(posedge clk);
		if (hold_output) begin
			stats_if.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_output = 1'b0;
		end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
			stats_if.ready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end else begin
			stats_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && stats_if.valid && stats_if.ready) board.match_record(stats_if.data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (stats_if.valid && stats_if.ready) ||
					(psel && penable && pready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic logic [TIME_W-1:0] any_time();
		return TIME_W'({$urandom(), $urandom()});
	endfunction

	function automatic longint clamp_time(longint t);
		if (t < 0) return 0;
		if (t > TIME_MAX) return TIME_MAX;
		return t;
	endfunction

	function automatic plstat_req_t sample_req(logic src, logic [KIND_W-1:0] kind,
			longint recv, longint other);
		plstat_req_t r;
		r = '0;
		r.req_type = REQ_SAMPLE;
		r.source = src;
		r.kind = kind;
		r.recv_time_us = recv[TIME_W-1:0];
		r.other_time_us = other[TIME_W-1:0];
		return r;
	endfunction

	function automatic plstat_req_t flush_req(longint now, logic force_all);
		plstat_req_t r;
		r = '0;
		r.req_type = REQ_FLUSH;
		r.recv_time_us = now[TIME_W-1:0];
		r.force_req = force_all;
		return r;
	endfunction

	function automatic plstat_req_t random_request();
		plstat_req_t r;
		longint recv;
		longint other;
		longint lim;
		longint dly;
		int pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0) cur_minute = (cur_minute + $urandom_range(1, 3)) % (LAST_MINUTE + 1);
		recv = clamp_time(longint'(cur_minute) * MINUTE_US + $urandom_range(0, MINUTE_US - 1));
		r.req_type = REQ_SAMPLE;
		r.source = 1'($urandom_range(0, 1));
		r.kind = ($urandom_range(0, 9) == 0) ? KIND_UNKNOWN : KIND_W'($urandom_range(KIND_TICK, KIND_DEAL));
		r.force_req = 1'($urandom_range(0, 1));
		if (pick < 8) begin
			r.req_type = REQ_FLUSH;
			r.force_req = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 1)) recv = clamp_time(recv + MINUTE_US);
			r.recv_time_us = recv[TIME_W-1:0];
			r.other_time_us = any_time();
		end else if (pick < 14) begin
			r.recv_time_us = any_time();
			r.other_time_us = any_time();
		end else begin
			lim = (r.source == SRC_INTERNAL) ? board.internal_limit : board.push_limit;
			case ($urandom_range(0, 9))
				0: dly = lim;
				1: dly = lim + $urandom_range(1, 1000);
				2: dly = -longint'($urandom_range(1, 1000000));
				3: dly = 0;
				default: dly = $urandom_range(0, lim);
			endcase
			other = (r.source == SRC_INTERNAL) ? recv + dly : recv - dly;
			r.recv_time_us = recv[TIME_W-1:0];
			r.other_time_us = TIME_W'(clamp_time(other));
		end
		return r;
	endfunction

	task automatic send_request(input plstat_req_t r);
		int gap;
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		board.absorb_request(r);
		requests_sent++;
		gap = (src_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic run_random(input int n);
		cur_minute = $urandom_range(0, LAST_MINUTE);
		repeat (n) send_request(random_request());
	endtask

	task automatic settle_block();
		req_if.valid <= 1'b0;
		while (board.pending_records.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		board.set_limit(idx, val);
	endtask

	task automatic set_limits(input logic [DATA_W-1:0] push_val, input logic [DATA_W-1:0] int_val);
		write_limit(REG_PUSH_LIMIT, push_val);
		write_limit(REG_INTERNAL_LIMIT, int_val);
		limit_settings++;
	endtask

	task automatic run_directed();
		send_request(sample_req(SRC_PUSH, KIND_TICK, 0, 0));
		send_request(sample_req(SRC_PUSH, KIND_TICK, 1000, 0));
		send_request(sample_req(SRC_PUSH, KIND_ORDER, 60000005, 5));
		send_request(sample_req(SRC_PUSH, KIND_DEAL, 700000000, 100000000));
		send_request(sample_req(SRC_PUSH, KIND_DEAL, 700000001, 100000000));
		send_request(sample_req(SRC_PUSH, KIND_DEAL, 5, 10));
		send_request(sample_req(SRC_INTERNAL, KIND_TICK, 120000000, 180000000));
		send_request(sample_req(SRC_INTERNAL, KIND_ORDER, 120000000, 180000001));
		send_request(sample_req(SRC_INTERNAL, KIND_DEAL, TIME_MAX, 0));
		send_request(sample_req(SRC_PUSH, KIND_UNKNOWN, 1000, 0));
		send_request(sample_req(SRC_PUSH, KIND_TICK, 61000000, 60999993));
		send_request(sample_req(SRC_PUSH, KIND_TICK, 64'd86399999999, 64'd86399999996));
		send_request(sample_req(SRC_PUSH, KIND_ORDER, TIME_MAX, TIME_MAX - 1));
		send_request(sample_req(SRC_INTERNAL, KIND_DEAL, TIME_MAX, TIME_MAX));
		send_request(flush_req(0, 1'b0));
		send_request(flush_req(TIME_MAX, 1'b0));
		send_request(flush_req(0, 1'b1));
		send_request(flush_req(0, 1'b1));
		for (int b = 0; b < BUCKETS; b++)
			send_request(sample_req(b >= KINDS, KIND_W'(b % KINDS), 300000000 + 10 * b,
				(b >= KINDS) ? 300000000 + 11 * b : 300000000 - b));
		send_request(flush_req(359999999, 1'b0));
		send_request(flush_req(359999999, 1'b1));
	endtask

	initial begin
		board = new();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		hold_output = 1'b0;
		requests_sent = 0;
		limit_settings = 1;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		stats_if.ready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle_block();

		set_limits(0, LIMIT_TOP);
		run_random(100);
		settle_block();

		set_limits(LIMIT_TOP, 0);
		run_random(100);
		settle_block();

		set_limits($urandom_range(0, LIMIT_TOP), $urandom_range(0, LIMIT_TOP));
		hold_output = 1'b1;
		run_random(100);
		settle_block();

		set_limits(PUSH_LIMIT_RST, INTERNAL_LIMIT_RST);
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		run_random(110);
		settle_block();

		if (board.pending_records.size() != 0) begin
			$display("%0t: %0d records never arrived", $time, board.pending_records.size());
			board.mismatch_count += board.pending_records.size();
		end
		$display("sent %0d requests under %0d limit settings, checked %0d bucket records",
			requests_sent, limit_settings, board.records_seen);
		$display("run included a long output stall, source and sink gaps, and a gap-free tail");
		if (board.mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
